// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the trilinear volume interpolation RTL.
// No dependencies; include from any module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond at one edge implies expr at the same edge.
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Check that cond at one edge implies expr at the following edge.
`define ASSERT_IMPLY_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/tvi_pkg.sv =====
// Package for the trilinear volume interpolation unit: sizes, widths and codes.
// No dependencies; the interfaces, the bank and the top module import it.
package tvi_pkg;

   // Storage and arithmetic sizes
   localparam int AXIS_POINTS = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 12;

   localparam int CELL_BITS      = $clog2(AXIS_POINTS);
   localparam int SIZE_BITS      = 5;
   localparam int EXT_BITS       = (SIZE_BITS > CELL_BITS + 1) ? SIZE_BITS : CELL_BITS + 1;
   localparam int HALF_BITS      = CELL_BITS - 1;
   localparam int BANK_ADDR_BITS = 3 * HALF_BITS;
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
   localparam int BANKS          = 8;
   localparam int WEIGHT_BITS    = FRAC_BITS + 1;
   localparam int X_BITS         = SAMPLE_BITS + FRAC_BITS;
   localparam int C_BITS         = SAMPLE_BITS + 2 * FRAC_BITS;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [EXT_BITS-1:0]    EXT_LIMIT  = EXT_BITS'(AXIS_POINTS);

   // Transaction kinds
   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NEGATIVE = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2
   } reg_index_type;

   // Per-query control carried down the blend pipeline
   typedef struct packed {
      logic                 outside;
      logic [FRAC_BITS-1:0] frac_y;
      logic [FRAC_BITS-1:0] frac_z;
   } meta_type;

endpackage

// ===== rtl/core/tvi_if.sv =====
// Channel interfaces of the trilinear volume interpolation unit.
// Depends on tvi_pkg for field widths.
interface tvi_req_if import tvi_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [CELL_BITS-1:0]          cell_x;
   logic [CELL_BITS-1:0]          cell_y;
   logic [CELL_BITS-1:0]          cell_z;
   logic [FRAC_BITS-1:0]          frac_x;
   logic [FRAC_BITS-1:0]          frac_y;
   logic [FRAC_BITS-1:0]          frac_z;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, kind, cell_x, cell_y, cell_z, frac_x, frac_y, frac_z,
                   sample_in, input ready);
   modport sink (input valid, kind, cell_x, cell_y, cell_z, frac_x, frac_y, frac_z,
                 sample_in, output ready);
endinterface

interface tvi_rsp_if import tvi_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] value;
   logic [1:0]                    status;

   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

interface tvi_csr_if import tvi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           index;
   logic [SIZE_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tvi_bank.sv =====
// One parity bank of the voxel store: synchronous RAM, one write and one read port.
// Depends on tvi_pkg for depth and sample width.
module tvi_bank import tvi_pkg::*; (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [BANK_ADDR_BITS-1:0] wr_addr,
   input  logic [SAMPLE_BITS-1:0]    wr_data,
   input  logic                      rd_en,
   input  logic [BANK_ADDR_BITS-1:0] rd_addr,
   output logic [SAMPLE_BITS-1:0]    rd_data
);

   logic [SAMPLE_BITS-1:0] mem_ff [BANK_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   // Store the sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/trilinear_volume_interpolation_unit.sv =====
// Trilinear volume interpolation unit: voxel store in eight parity banks plus blend pipeline.
// A query passes the bank read, the x, y and z blend registers and the output register.
// One transaction per cycle unless rsp_if stalls; each of the eight banks reads one corner.
// Writes take no result and land in the bank at the accept edge.
// Reset (synchronous) clears the pipeline valids and sets the size registers to 16;
// the voxel store is not cleared and is undefined until written.
`include "assert_macros.svh"

module trilinear_volume_interpolation_unit import tvi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tvi_req_if.sink   req_if,
   tvi_rsp_if.source rsp_if,
   tvi_csr_if.sink   csr_if
);

   // Size registers
   logic [SIZE_BITS-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [SIZE_BITS-1:0] size_x_in, size_y_in, size_z_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_SIZE_X: size_x_in = csr_if.data;
            REG_SIZE_Y: size_y_in = csr_if.data;
            REG_SIZE_Z: size_z_in = csr_if.data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_BITS'(16);
         size_y_ff <= SIZE_BITS'(16);
         size_z_ff <= SIZE_BITS'(16);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   // Stage advance: a stage moves when the next one is empty or moving
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, rsp_valid_in;
   logic en0, en1, en2, en3, en4;
   logic accept, is_query;

   assign en4 = !rsp_valid_ff || rsp_if.ready;
   assign en3 = !s4_valid_ff || en4;
   assign en2 = !s3_valid_ff || en3;
   assign en1 = !s2_valid_ff || en2;
   assign en0 = !s1_valid_ff || en1;

   assign req_if.ready = en0;
   assign accept       = req_if.valid && en0;
   assign is_query     = (req_if.kind == KIND_QUERY);

   assign s1_valid_in  = en0 ? (accept && is_query) : s1_valid_ff;
   assign s2_valid_in  = en1 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = en2 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in  = en3 ? s3_valid_ff : s4_valid_ff;
   assign rsp_valid_in = en4 ? s4_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Grid check: the upper corner must lie inside the extent on every axis
   logic [EXT_BITS-1:0] ext_x, ext_y, ext_z;
   logic [EXT_BITS-1:0] up_x, up_y, up_z;
   logic                outside;

   always_comb begin
      ext_x   = (EXT_BITS'(size_x_ff) < EXT_LIMIT) ? EXT_BITS'(size_x_ff) : EXT_LIMIT;
      ext_y   = (EXT_BITS'(size_y_ff) < EXT_LIMIT) ? EXT_BITS'(size_y_ff) : EXT_LIMIT;
      ext_z   = (EXT_BITS'(size_z_ff) < EXT_LIMIT) ? EXT_BITS'(size_z_ff) : EXT_LIMIT;
      up_x    = EXT_BITS'(req_if.cell_x) + EXT_BITS'(1);
      up_y    = EXT_BITS'(req_if.cell_y) + EXT_BITS'(1);
      up_z    = EXT_BITS'(req_if.cell_z) + EXT_BITS'(1);
      outside = (up_x >= ext_x) || (up_y >= ext_y) || (up_z >= ext_z);
   end

   // Write decode: bank from the low coordinate bits, address from the rest
   logic                      wr_in_range;
   logic [2:0]                wr_bank;
   logic [BANK_ADDR_BITS-1:0] wr_addr;

   assign wr_in_range = (EXT_BITS'(req_if.cell_x) < EXT_LIMIT)
                     && (EXT_BITS'(req_if.cell_y) < EXT_LIMIT)
                     && (EXT_BITS'(req_if.cell_z) < EXT_LIMIT);
   assign wr_bank = {req_if.cell_x[0], req_if.cell_y[0], req_if.cell_z[0]};
   assign wr_addr = {req_if.cell_x[CELL_BITS-1:1], req_if.cell_y[CELL_BITS-1:1],
                     req_if.cell_z[CELL_BITS-1:1]};

   // Corner banks: each bank serves the one corner whose parity matches it
   logic [SAMPLE_BITS-1:0] rd_data [BANKS];

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      localparam logic [2:0] BANK_ID = 3'(b);
      logic [CELL_BITS:0]        cx, cy, cz;
      logic [BANK_ADDR_BITS-1:0] rd_addr;
      logic                      wr_en;

      assign cx = (CELL_BITS + 1)'(req_if.cell_x)
                + (CELL_BITS + 1)'(BANK_ID[2] ^ req_if.cell_x[0]);
      assign cy = (CELL_BITS + 1)'(req_if.cell_y)
                + (CELL_BITS + 1)'(BANK_ID[1] ^ req_if.cell_y[0]);
      assign cz = (CELL_BITS + 1)'(req_if.cell_z)
                + (CELL_BITS + 1)'(BANK_ID[0] ^ req_if.cell_z[0]);
      assign rd_addr = {cx[CELL_BITS-1:1], cy[CELL_BITS-1:1], cz[CELL_BITS-1:1]};
      assign wr_en   = accept && !is_query && wr_in_range && (wr_bank == BANK_ID);

      tvi_bank u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (req_if.sample_in),
         .rd_en   (accept && is_query),
         .rd_addr (rd_addr),
         .rd_data (rd_data[b])
      );
   end

   // Stage 1 payload: corner parity and fractions beside the bank read
   logic [2:0]           parity_ff;
   logic [FRAC_BITS-1:0] frac_x_ff;
   meta_type             meta1_ff, meta2_ff, meta3_ff, meta4_ff;
   meta_type             meta1_in;

   assign meta1_in = '{outside: outside, frac_y: req_if.frac_y, frac_z: req_if.frac_z};

   always_ff @(posedge clock) begin
      if (en0) begin
         parity_ff <= {req_if.cell_x[0], req_if.cell_y[0], req_if.cell_z[0]};
         frac_x_ff <= req_if.frac_x;
         meta1_ff  <= meta1_in;
      end
   end

   // Stage 2: blend along x, one line per (dy, dz)
   logic [X_BITS-1:0]      a_ff [4];
   logic [X_BITS-1:0]      a_in [4];
   logic [X_BITS:0]        wx0_e, wx1_e;
   logic [SAMPLE_BITS-1:0] corner_lo, corner_hi;
   logic [X_BITS:0]        ax_sum;

   always_comb begin
      wx1_e = (X_BITS + 1)'(frac_x_ff);
      wx0_e = (X_BITS + 1)'(WEIGHT_ONE) - wx1_e;
      for (int j = 0; j < 4; j++) begin
         corner_lo = rd_data[3'(j) ^ parity_ff] ^ SAMPLE_TOP;
         corner_hi = rd_data[(3'(j) | 3'd4) ^ parity_ff] ^ SAMPLE_TOP;
         ax_sum    = (X_BITS + 1)'(corner_lo) * wx0_e + (X_BITS + 1)'(corner_hi) * wx1_e;
         a_in[j]   = ax_sum[X_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         a_ff     <= a_in;
         meta2_ff <= meta1_ff;
      end
   end

   // Stage 3: blend along y and round back to one fraction field
   localparam logic [C_BITS:0] HALF_Y = (C_BITS + 1)'(1) << (FRAC_BITS - 1);
   logic [X_BITS-1:0] b0_ff, b1_ff, b0_in, b1_in;
   logic [C_BITS:0]   wy0_e, wy1_e, by0_sum, by1_sum;

   always_comb begin
      wy1_e   = (C_BITS + 1)'(meta2_ff.frac_y);
      wy0_e   = (C_BITS + 1)'(WEIGHT_ONE) - wy1_e;
      by0_sum = (C_BITS + 1)'(a_ff[0]) * wy0_e + (C_BITS + 1)'(a_ff[2]) * wy1_e + HALF_Y;
      by1_sum = (C_BITS + 1)'(a_ff[1]) * wy0_e + (C_BITS + 1)'(a_ff[3]) * wy1_e + HALF_Y;
      b0_in   = by0_sum[FRAC_BITS +: X_BITS];
      b1_in   = by1_sum[FRAC_BITS +: X_BITS];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         meta3_ff <= meta2_ff;
      end
   end

   // Stage 4: blend along z at full precision
   logic [C_BITS-1:0] c_ff, c_in;
   logic [C_BITS:0]   wz0_e, wz1_e, cz_sum;

   always_comb begin
      wz1_e  = (C_BITS + 1)'(meta3_ff.frac_z);
      wz0_e  = (C_BITS + 1)'(WEIGHT_ONE) - wz1_e;
      cz_sum = (C_BITS + 1)'(b0_ff) * wz0_e + (C_BITS + 1)'(b1_ff) * wz1_e;
      c_in   = cz_sum[C_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         c_ff     <= c_in;
         meta4_ff <= meta3_ff;
      end
   end

   // Output register: round, remove the bias, pick the status
   localparam logic [C_BITS:0] HALF_Z = (C_BITS + 1)'(1) << (2 * FRAC_BITS - 1);
   logic [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [C_BITS:0]        r_sum;

   always_comb begin
      r_sum = (C_BITS + 1)'(c_ff) + HALF_Z;
      priority if (meta4_ff.outside) begin
         rsp_value_in  = '0;
         rsp_status_in = STATUS_OUTSIDE;
      end else begin
         rsp_value_in  = r_sum[2 * FRAC_BITS +: SAMPLE_BITS] ^ SAMPLE_TOP;
         rsp_status_in = c_ff[C_BITS-1] ? STATUS_OK : STATUS_NEGATIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.value  = $signed(rsp_value_ff);
   assign rsp_if.status = rsp_status_ff;

   // Checks
   `ASSERT_IMPLY_NEXT(a_query_enters, clock, reset, accept && is_query, s1_valid_ff)
   `ASSERT_IMPLY_NEXT(a_write_no_slot, clock, reset, accept && !is_query, !s1_valid_ff)
   `ASSERT_IMPLY_NEXT(a_s4_holds, clock, reset, s4_valid_ff && !en4,
                      s4_valid_ff && $stable(c_ff))
   `ASSERT_IMPLY(a_outside_zero, clock, reset,
                 rsp_valid_ff && (rsp_status_ff == STATUS_OUTSIDE), rsp_value_ff == '0)

endmodule

// ===== dv/tb_trilinear_volume_interpolation_unit.sv =====
// Self-checking testbench for trilinear_volume_interpolation_unit.
// Depends on tvi_pkg and the tvi_req_if / tvi_rsp_if / tvi_csr_if interfaces;
// a shadow voxel store and lerp predictor check every query result in order.
`timescale 1ns / 100ps

module tb_trilinear_volume_interpolation_unit;
   import tvi_pkg::*;

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          DRAIN_CYCLES    = 10;
   localparam int          PHASES          = 10;
   localparam int          ITEMS_PER_PHASE = 100;
   localparam int          REPORT_LIMIT    = 10;
   localparam logic [1:0]  REG_UNUSED      = 2'd3;

   // One request transaction, optionally with a hand-written expectation
   typedef struct {
      kind_type                      kind;
      logic [CELL_BITS-1:0]          cx, cy, cz;
      logic [FRAC_BITS-1:0]          fx, fy, fz;
      logic signed [SAMPLE_BITS-1:0] sample;
      bit                            known;
      logic signed [SAMPLE_BITS-1:0] known_value;
      status_type                    known_status;
   } voxel_op_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] value;
      status_type                    status;
   } interp_result_type;

   logic clock;
   logic reset;

   tvi_req_if req_bus ();
   tvi_rsp_if rsp_bus ();
   tvi_csr_if csr_bus ();

   trilinear_volume_interpolation_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Shadow copy of the block state
   logic [SAMPLE_BITS-1:0] shadow_volume [AXIS_POINTS*AXIS_POINTS*AXIS_POINTS];
   logic [SIZE_BITS-1:0]   shadow_size_x, shadow_size_y, shadow_size_z;

   // Stimulus-side record of voxels that hold a defined value
   bit voxel_written [AXIS_POINTS*AXIS_POINTS*AXIS_POINTS];

   interp_result_type pending_interp [$];
   voxel_op_type      directed_ops [$];
   voxel_op_type      cur_op;

   int  cycle_count;
   int  mismatches;
   int  results_checked;
   int  requests_sent;
   int  queries_sent;
   bit  idle_on;
   int  rsp_hold_left;

   always #5 clock = ~clock;

   // Append a row to the directed table
   function automatic void add_row(voxel_op_type op);
      directed_ops = {directed_ops, op};
   endfunction

   // Append an expected result to the scoreboard
   function automatic void queue_result(interp_result_type r);
      pending_interp = {pending_interp, r};
   endfunction

   function automatic logic [EXT_BITS-1:0] extent_of(logic [SIZE_BITS-1:0] sz);
      return (EXT_BITS'(sz) < EXT_LIMIT) ? EXT_BITS'(sz) : EXT_LIMIT;
   endfunction

   function automatic bit cell_fits(logic [CELL_BITS-1:0] c, logic [SIZE_BITS-1:0] sz);
      return (EXT_BITS'(c) + EXT_BITS'(1)) < extent_of(sz);
   endfunction

   function automatic logic [63:0] lerp_pair(logic [63:0] lo, logic [63:0] hi,
                                             logic [FRAC_BITS-1:0] f);
      return lo * (64'(WEIGHT_ONE) - 64'(f)) + hi * 64'(f);
   endfunction

   // Stored sample at a corner, sign bit flipped so the arithmetic is unsigned
   function automatic logic [63:0] biased_voxel(logic [CELL_BITS-1:0] x,
                                                logic [CELL_BITS-1:0] y,
                                                logic [CELL_BITS-1:0] z);
      return 64'(shadow_volume[{x, y, z}] ^ SAMPLE_TOP);
   endfunction

   // Blend eight corners along x, then y (rounded), then z, and round to a sample
   function automatic interp_result_type interpolate_cell(
         logic [CELL_BITS-1:0] cx, logic [CELL_BITS-1:0] cy, logic [CELL_BITS-1:0] cz,
         logic [FRAC_BITS-1:0] fx, logic [FRAC_BITS-1:0] fy, logic [FRAC_BITS-1:0] fz);
      interp_result_type    res;
      logic [CELL_BITS-1:0] nx, ny, nz;
      logic [63:0]          a00, a10, a01, a11, b0, b1, cz_sum, rounded;
      if (!cell_fits(cx, shadow_size_x) || !cell_fits(cy, shadow_size_y) ||
          !cell_fits(cz, shadow_size_z)) begin
         res.value  = '0;
         res.status = STATUS_OUTSIDE;
         return res;
      end
      nx = cx + 1'b1;
      ny = cy + 1'b1;
      nz = cz + 1'b1;
      a00 = lerp_pair(biased_voxel(cx, cy, cz), biased_voxel(nx, cy, cz), fx);
      a10 = lerp_pair(biased_voxel(cx, ny, cz), biased_voxel(nx, ny, cz), fx);
      a01 = lerp_pair(biased_voxel(cx, cy, nz), biased_voxel(nx, cy, nz), fx);
      a11 = lerp_pair(biased_voxel(cx, ny, nz), biased_voxel(nx, ny, nz), fx);
      b0 = (lerp_pair(a00, a10, fy) + (64'(WEIGHT_ONE) >> 1)) >> FRAC_BITS;
      b1 = (lerp_pair(a01, a11, fy) + (64'(WEIGHT_ONE) >> 1)) >> FRAC_BITS;
      cz_sum  = lerp_pair(b0, b1, fz);
      rounded = (cz_sum + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      res.value  = rounded[SAMPLE_BITS-1:0] ^ SAMPLE_TOP;
      res.status = (cz_sum < (64'(SAMPLE_TOP) << (2 * FRAC_BITS))) ?
                   STATUS_NEGATIVE : STATUS_OK;
      return res;
   endfunction

   function automatic voxel_op_type make_write(int x, int y, int z, int s);
      voxel_op_type op;
      op.kind   = KIND_WRITE;
      op.cx     = x[CELL_BITS-1:0];
      op.cy     = y[CELL_BITS-1:0];
      op.cz     = z[CELL_BITS-1:0];
      op.fx     = FRAC_BITS'($urandom_range(0, 4095));
      op.fy     = FRAC_BITS'($urandom_range(0, 4095));
      op.fz     = FRAC_BITS'($urandom_range(0, 4095));
      op.sample = s[SAMPLE_BITS-1:0];
      op.known  = 1'b0;
      op.known_value  = '0;
      op.known_status = STATUS_OK;
      return op;
   endfunction

   function automatic voxel_op_type make_query(int x, int y, int z, int fx, int fy, int fz);
      voxel_op_type op;
      op = make_write(x, y, z, $urandom);
      op.kind = KIND_QUERY;
      op.fx   = fx[FRAC_BITS-1:0];
      op.fy   = fy[FRAC_BITS-1:0];
      op.fz   = fz[FRAC_BITS-1:0];
      return op;
   endfunction

   function automatic voxel_op_type known(voxel_op_type op, int v, status_type st);
      op.known        = 1'b1;
      op.known_value  = v[SAMPLE_BITS-1:0];
      op.known_status = st;
      return op;
   endfunction

   // Random sample with extra weight on the range ends and values near zero
   function automatic int rand_sample();
      case ($urandom_range(0, 7))
         0:       return 32767;
         1:       return -32768;
         2:       return $signed($urandom_range(0, 8)) - 4;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic int rand_frac();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 4095;
         2:       return 2048;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   // Size register value: mostly a usable grid, sometimes any encoding
   function automatic logic [SIZE_BITS-1:0] rand_size();
      if ($urandom_range(0, 7) == 0)
         return SIZE_BITS'($urandom_range(0, 31));
      return SIZE_BITS'($urandom_range(2, 16));
   endfunction

   // Coordinate mostly inside the configured grid, sometimes anywhere in storage
   function automatic int rand_coord(logic [SIZE_BITS-1:0] sz);
      int ext;
      ext = int'(extent_of(sz));
      if (ext >= 2 && $urandom_range(0, 4) != 0)
         return $urandom_range(0, ext - 2);
      return $urandom_range(0, AXIS_POINTS - 1);
   endfunction

   // Drive one request at the falling edge and hold it until accepted
   task automatic push_voxel_op(voxel_op_type op);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      cur_op            = op;
      req_bus.kind      = op.kind;
      req_bus.cell_x    = op.cx;
      req_bus.cell_y    = op.cy;
      req_bus.cell_z    = op.cz;
      req_bus.frac_x    = op.fx;
      req_bus.frac_y    = op.fy;
      req_bus.frac_z    = op.fz;
      req_bus.sample_in = op.sample;
      req_bus.valid     = 1'b1;
      if (op.kind == KIND_WRITE)
         voxel_written[{op.cx, op.cy, op.cz}] = 1'b1;
      else
         queries_sent++;
      requests_sent++;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Leaves csr valid high; the caller lowers it after the last write
   task automatic write_size_reg(logic [1:0] idx, logic [SIZE_BITS-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (pending_interp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Predict on every accepted request, check every accepted result
   always @(posedge clock) begin
      interp_result_type expd;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_interp.size() == 0) begin
               note_mismatch($sformatf("unexpected result value %0d status %0d",
                                       rsp_bus.value, rsp_bus.status));
            end else begin
               expd = pending_interp.pop_front();
               results_checked++;
               if (rsp_bus.value !== expd.value || rsp_bus.status !== expd.status)
                  note_mismatch($sformatf(
                     "expected value %0d status %0d, got value %0d status %0d",
                     expd.value, expd.status, rsp_bus.value, rsp_bus.status));
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            if (req_bus.kind == KIND_WRITE) begin
               shadow_volume[{req_bus.cell_x, req_bus.cell_y, req_bus.cell_z}] =
                  req_bus.sample_in;
            end else if (cur_op.known) begin
               expd.value  = cur_op.known_value;
               expd.status = cur_op.known_status;
               queue_result(expd);
            end else begin
               queue_result(interpolate_cell(
                  req_bus.cell_x, req_bus.cell_y, req_bus.cell_z,
                  req_bus.frac_x, req_bus.frac_y, req_bus.frac_z));
            end
         end
         if (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1) begin
            case (csr_bus.index)
               REG_SIZE_X: shadow_size_x = csr_bus.data;
               REG_SIZE_Y: shadow_size_y = csr_bus.data;
               REG_SIZE_Z: shadow_size_z = csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   // Result backpressure in short random bursts
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_bus.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         rsp_hold_left = $urandom_range(1, 3) - 1;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_interp.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [SIZE_BITS-1:0] sx, sy, sz;
      voxel_op_type         op;
      int                   sent;
      int                   qx, qy, qz;
      bit                   in_grid;

      clock = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      mismatches = 0;
      results_checked = 0;
      requests_sent = 0;
      queries_sent = 0;
      rsp_hold_left = 0;
      idle_on = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_WRITE;
      req_bus.cell_x = '0;
      req_bus.cell_y = '0;
      req_bus.cell_z = '0;
      req_bus.frac_x = '0;
      req_bus.frac_y = '0;
      req_bus.frac_z = '0;
      req_bus.sample_in = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_SIZE_X;
      csr_bus.data = '0;
      shadow_size_x = 5'd16;
      shadow_size_y = 5'd16;
      shadow_size_z = 5'd16;
      foreach (shadow_volume[i]) shadow_volume[i] = '0;
      foreach (voxel_written[i]) voxel_written[i] = 1'b0;
      cur_op = make_write(0, 0, 0, 0);

      // Directed rows: range ends of samples and fractions, grid edges, rounding to zero
      add_row(known(make_query(15, 15, 15, 0, 0, 0), 0, STATUS_OUTSIDE));
      add_row(make_write(0, 0, 0, 32767));
      add_row(make_write(1, 0, 0, -1));
      add_row(make_write(0, 1, 0, 0));
      add_row(make_write(0, 0, 1, 1));
      add_row(make_write(1, 1, 0, -32768));
      add_row(make_write(1, 0, 1, 32767));
      add_row(make_write(0, 1, 1, -2));
      add_row(make_write(1, 1, 1, -32768));
      add_row(known(make_query(0, 0, 0, 0, 0, 0), 32767, STATUS_OK));
      add_row(make_query(0, 0, 0, 4095, 4095, 4095));
      add_row(make_query(0, 0, 0, 2048, 2048, 2048));
      add_row(make_query(0, 0, 0, 4095, 0, 0));
      add_row(make_query(0, 0, 0, 0, 4095, 0));
      add_row(make_query(0, 0, 0, 0, 0, 4095));
      add_row(make_write(0, 0, 0, 0));
      // Midway between 0 and -1: negative before rounding, zero after
      add_row(make_query(0, 0, 0, 2048, 0, 0));
      add_row(known(make_query(0, 0, 0, 0, 0, 0), 0, STATUS_OK));
      add_row(known(make_query(0, 0, 15, 1, 1, 1), 0, STATUS_OUTSIDE));
      add_row(known(make_query(0, 15, 0, 4095, 4095, 4095), 0, STATUS_OUTSIDE));
      add_row(make_write(15, 15, 15, -32768));
      add_row(known(make_query(15, 0, 0, 0, 0, 0), 0, STATUS_OUTSIDE));

      // Keep reset asserted, then release it before the directed rows
      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (directed_ops[i]) push_voxel_op(directed_ops[i]);

      // Size settings: fixed extremes first, then random, full size and no idling last
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin sx = 5'd2;  sy = 5'd2;  sz = 5'd2;  end
            1: begin sx = 5'd0;  sy = 5'd1;  sz = 5'd31; end
            2: begin sx = 5'd31; sy = 5'd17; sz = 5'd16; end
            3: begin sx = 5'd16; sy = 5'd2;  sz = 5'd3;  end
            PHASES - 1: begin sx = 5'd16; sy = 5'd16; sz = 5'd16; end
            default: begin
               sx = rand_size();
               sy = rand_size();
               sz = rand_size();
            end
         endcase
         write_size_reg(REG_SIZE_X, sx);
         write_size_reg(REG_SIZE_Y, sy);
         write_size_reg(REG_SIZE_Z, sz);
         // Index with no register behind it must leave the sizes alone
         if (phase < 2 || $urandom_range(0, 2) == 0)
            write_size_reg(REG_UNUSED, SIZE_BITS'($urandom_range(0, 31)));
         csr_bus.valid = 1'b0;
         idle_on = (phase != PHASES - 1);

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 3) begin
               // Stray write, may overwrite a corner already in use
               qx = rand_coord(sx) + $urandom_range(0, 1);
               qy = rand_coord(sy) + $urandom_range(0, 1);
               qz = rand_coord(sz) + $urandom_range(0, 1);
               push_voxel_op(make_write(qx % AXIS_POINTS, qy % AXIS_POINTS,
                                        qz % AXIS_POINTS, rand_sample()));
               sent++;
            end else begin
               qx = rand_coord(sx);
               qy = rand_coord(sy);
               qz = rand_coord(sz);
               in_grid = cell_fits(CELL_BITS'(qx), sx) && cell_fits(CELL_BITS'(qy), sy) &&
                         cell_fits(CELL_BITS'(qz), sz);
               // Load any undefined corner first, refresh some of the others
               if (in_grid) begin
                  for (int k = 0; k < 8; k++) begin
                     op = make_write(qx + k[2], qy + k[1], qz + k[0], rand_sample());
                     if (!voxel_written[{op.cx, op.cy, op.cz}] || $urandom_range(0, 3) == 0) begin
                        push_voxel_op(op);
                        sent++;
                     end
                  end
               end
               push_voxel_op(make_query(qx, qy, qz, rand_frac(), rand_frac(), rand_frac()));
               sent++;
            end
         end
      end

      // Drain and let the pipeline settle
      wait_idle();
      $display("%0d requests sent (%0d queries), %0d results checked over %0d size settings",
               requests_sent, queries_sent, results_checked, PHASES + 1);
      if (mismatches == 0 && pending_interp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches,
                  pending_interp.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
